[design/tlvd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvd_pkg
// Shared types, codes and message tables for the message deframer.
// ----------------------------------------------------------------------------
package tlvd_pkg;

    localparam int TABLE_LEN       = 11;
    localparam int NUM_MSGS        = 11;
    localparam int MAX_PAYLOAD_DEF = 16;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 64;
    localparam logic [3:0] NO_ENTRY = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IDS_LOW  = 1'b0,
        REG_IDS_HIGH = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STAT_FIELD   = 2'd0,
        STAT_UNKNOWN = 2'd1,
        STAT_LENGTH  = 2'd2,
        STAT_LINK    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_HALF = 2'd1,
        KIND_WORD = 2'd2
    } kind_t;

    typedef enum logic {
        FRM_RECV,
        FRM_EMIT
    } frm_state_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_READ,
        EM_ACC,
        EM_PUSH
    } em_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       link_lost;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  message_id;
        logic [3:0]  table_entry;
        logic [3:0]  field_number;
        kind_t       field_kind;
        logic [31:0] field_value;
        logic        last;
    } out_item_t;

    // payload size in bytes per table entry
    function automatic logic [4:0] entry_size(input logic [3:0] entry);
        logic [4:0] sz;
        case (entry)
            4'd0, 4'd1:       sz = 5'd9;
            4'd2, 4'd3, 4'd4: sz = 5'd1;
            4'd5, 4'd6, 4'd7: sz = 5'd8;
            4'd8:             sz = 5'd5;
            4'd9:             sz = 5'd16;
            4'd10:            sz = 5'd10;
            default:          sz = 5'd0;
        endcase
        return sz;
    endfunction

    // index of the final field per table entry
    function automatic logic [3:0] last_field(input logic [3:0] entry);
        logic [3:0] lf;
        case (entry)
            4'd0, 4'd1:       lf = 4'd2;
            4'd2, 4'd3, 4'd4: lf = 4'd0;
            4'd5, 4'd6, 4'd7: lf = 4'd1;
            4'd8:             lf = 4'd4;
            4'd9:             lf = 4'd15;
            4'd10:            lf = 4'd2;
            default:          lf = 4'd0;
        endcase
        return lf;
    endfunction

    function automatic kind_t field_kind_of(input logic [3:0] entry,
                                            input logic [3:0] fnum);
        kind_t k;
        case (entry)
            4'd0, 4'd1:       k = (fnum < 4'd2) ? KIND_WORD : KIND_BYTE;
            4'd5, 4'd6, 4'd7: k = KIND_WORD;
            4'd10:            k = (fnum == 4'd0) ? KIND_HALF : KIND_WORD;
            default:          k = KIND_BYTE;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] kind_bytes_m1(input kind_t k);
        logic [1:0] n;
        case (k)
            KIND_HALF: n = 2'd1;
            KIND_WORD: n = 2'd3;
            default:   n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

[design/framed_message_deframer_unit.sv]
`timescale 1ns / 1ps
// A drop or link-lost item is in the output register the cycle after its input
//   is taken.
// Field drain after the last payload byte: each byte is read from the store (single
//   read port) and shifted in; each assembled field waits for the output register.
// Throughput: one input item per cycle while the output drains, not during emission.
// Reset: synchronous, active low; clears framing, config and sequencer, not the store.
// ----------------------------------------------------------------------------
// framed_message_deframer_unit
// Id / 16-bit length / payload deframer with a configurable id table.
// Known payloads are buffered in the store and emitted field by field.
// ----------------------------------------------------------------------------
module framed_message_deframer_unit #(
    parameter int MAX_PAYLOAD = tlvd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [tlvd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlvd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input bytes
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tlvd_pkg::in_item_t                  s_item,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output tlvd_pkg::out_item_t                 m_item
);

    localparam int AW = $clog2(MAX_PAYLOAD);

    // config registers
    logic [63:0] ids_low_reg;
    logic [23:0] ids_high_reg;

    // framing state
    tlvd_pkg::frm_state_t state_reg, state_next;
    logic [1:0]  hdr_count_reg, hdr_count_next;
    logic [7:0]  held_id_reg, held_id_next;
    logic [15:0] held_length_reg, held_length_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [3:0]  matched_entry_reg, matched_entry_next;
    logic        dropping_reg, dropping_next;
    logic [AW-1:0] pay_pos_reg, pay_pos_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    tlvd_pkg::out_item_t m_item_reg, m_item_next;

    // internal wires
    logic        s_fire;
    logic        out_free;
    logic        res_valid;
    tlvd_pkg::out_item_t res_item;
    logic [15:0] full_len;
    logic [3:0]  lookup_entry;
    logic [7:0]  entry_ids [tlvd_pkg::TABLE_LEN];
    logic        st_wr_en;
    logic        st_rd_en;
    logic [AW-1:0] st_rd_addr;
    logic [7:0]  st_rd_data;
    logic        emit_start;
    logic        fld_valid;
    logic        fld_ack;
    tlvd_pkg::out_item_t fld_item;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ids_low_reg  <= 64'd0;
            ids_high_reg <= 24'd0;
        end else if (cfg_wr_en) begin
            case (tlvd_pkg::cfg_reg_t'(cfg_index))
                tlvd_pkg::REG_IDS_LOW:  ids_low_reg  <= cfg_wdata;
                tlvd_pkg::REG_IDS_HIGH: ids_high_reg <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // id lookup: lowest matching entry below NUM_MSGS wins
    // ------------------------------------------------------------------
    assign full_len = {held_length_reg[15:8], s_item.data_byte};

    always_comb begin
        for (int i = 0; i < tlvd_pkg::TABLE_LEN; i++) begin
            if (i < 8) begin
                entry_ids[i] = ids_low_reg[8*(i%8) +: 8];
            end else begin
                entry_ids[i] = ids_high_reg[8*((i-8)%3) +: 8];
            end
        end
        lookup_entry = tlvd_pkg::NO_ENTRY;
        for (int i = tlvd_pkg::TABLE_LEN - 1; i >= 0; i--) begin
            if (i < tlvd_pkg::NUM_MSGS && entry_ids[i] == held_id_reg) begin
                lookup_entry = 4'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // framing
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == tlvd_pkg::FRM_RECV) && out_free;
    assign s_fire   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= tlvd_pkg::FRM_RECV;
            hdr_count_reg     <= 2'd0;
            held_id_reg       <= 8'd0;
            held_length_reg   <= 16'd0;
            remaining_reg     <= 16'd0;
            matched_entry_reg <= tlvd_pkg::NO_ENTRY;
            dropping_reg      <= 1'b0;
            pay_pos_reg       <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            hdr_count_reg     <= hdr_count_next;
            held_id_reg       <= held_id_next;
            held_length_reg   <= held_length_next;
            remaining_reg     <= remaining_next;
            matched_entry_reg <= matched_entry_next;
            dropping_reg      <= dropping_next;
            pay_pos_reg       <= pay_pos_next;
            m_valid_reg       <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    always_comb begin
        state_next         = state_reg;
        hdr_count_next     = hdr_count_reg;
        held_id_next       = held_id_reg;
        held_length_next   = held_length_reg;
        remaining_next     = remaining_reg;
        matched_entry_next = matched_entry_reg;
        dropping_next      = dropping_reg;
        pay_pos_next       = pay_pos_reg;
        st_wr_en           = 1'b0;
        emit_start         = 1'b0;
        res_valid          = 1'b0;
        res_item.status       = tlvd_pkg::STAT_LINK;
        res_item.message_id   = held_id_reg;
        res_item.table_entry  = tlvd_pkg::NO_ENTRY;
        res_item.field_number = 4'd0;
        res_item.field_kind   = tlvd_pkg::KIND_BYTE;
        res_item.field_value  = 32'd0;
        res_item.last         = 1'b1;

        if (s_fire) begin
            if (s_item.link_lost) begin
                hdr_count_next     = 2'd0;
                remaining_next     = 16'd0;
                dropping_next      = 1'b0;
                matched_entry_next = tlvd_pkg::NO_ENTRY;
                res_valid          = 1'b1;
            end else begin
                case (hdr_count_reg)
                    2'd0: begin
                        held_id_next   = s_item.data_byte;
                        hdr_count_next = 2'd1;
                    end
                    2'd1: begin
                        held_length_next = {s_item.data_byte, 8'd0};
                        hdr_count_next   = 2'd2;
                    end
                    2'd2: begin
                        held_length_next   = full_len;
                        remaining_next     = full_len;
                        matched_entry_next = lookup_entry;
                        pay_pos_next       = '0;
                        if (lookup_entry != tlvd_pkg::NO_ENTRY &&
                            full_len == {11'd0, tlvd_pkg::entry_size(lookup_entry)}) begin
                            dropping_next  = 1'b0;
                            hdr_count_next = 2'd3;
                        end else begin
                            // unknown id or size mismatch: report and skip
                            res_valid            = 1'b1;
                            res_item.status      = (lookup_entry == tlvd_pkg::NO_ENTRY) ?
                                                   tlvd_pkg::STAT_UNKNOWN :
                                                   tlvd_pkg::STAT_LENGTH;
                            res_item.table_entry = lookup_entry;
                            dropping_next        = (full_len != 16'd0);
                            hdr_count_next       = (full_len == 16'd0) ? 2'd0 : 2'd3;
                        end
                    end
                    default: begin
                        // payload byte
                        st_wr_en     = !dropping_reg;
                        pay_pos_next = pay_pos_reg + {{(AW-1){1'b0}}, 1'b1};
                        if (remaining_reg != 16'd0) begin
                            remaining_next = remaining_reg - 16'd1;
                        end
                        if (remaining_reg <= 16'd1) begin
                            hdr_count_next = 2'd0;
                            if (dropping_reg) begin
                                dropping_next = 1'b0;
                            end else begin
                                emit_start = 1'b1;
                                state_next = tlvd_pkg::FRM_EMIT;
                            end
                        end
                    end
                endcase
            end
        end

        // emission done once the final field is taken into the output register
        if (state_reg == tlvd_pkg::FRM_EMIT && fld_ack && fld_item.last) begin
            state_next = tlvd_pkg::FRM_RECV;
        end
    end

    // ------------------------------------------------------------------
    // output register: framing results and field results never coincide
    // ------------------------------------------------------------------
    assign fld_ack = fld_valid && out_free;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_item_next  = res_item;
        end else if (fld_ack) begin
            m_valid_next = 1'b1;
            m_item_next  = fld_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // ------------------------------------------------------------------
    // payload store and field sequencer
    // ------------------------------------------------------------------
    tlvd_store #(
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (pay_pos_reg),
        .wr_data (s_item.data_byte),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    tlvd_emit #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (emit_start),
        .entry      (matched_entry_reg),
        .message_id (held_id_reg),
        .rd_en      (st_rd_en),
        .rd_addr    (st_rd_addr),
        .rd_data    (st_rd_data),
        .fld_valid  (fld_valid),
        .fld_item   (fld_item),
        .fld_ack    (fld_ack)
    );

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_input_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tlvd_pkg::FRM_EMIT |-> !s_ready)
        else $error("input taken during field emission");

    a_fields_only_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        fld_valid |-> state_reg == tlvd_pkg::FRM_EMIT)
        else $error("field result outside emission");

    a_dropping_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        dropping_reg |-> hdr_count_reg == 2'd3)
        else $error("dropping outside payload phase");

    a_known_entry_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (hdr_count_reg == 2'd3 && !dropping_reg) |->
            matched_entry_reg < tlvd_pkg::NUM_MSGS)
        else $error("buffered payload without a table entry");

    a_emit_start_on_last_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_start |=> state_reg == tlvd_pkg::FRM_EMIT && hdr_count_reg == 2'd0)
        else $error("emission start without framing reset");

endmodule

[design/tlvd_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvd_store
// Payload byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlvd_store #(
    parameter int DEPTH = tlvd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/tlvd_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvd_emit
// Field sequencer: walks the stored payload byte by byte and assembles
// big-endian fields, one result item per field.
// ----------------------------------------------------------------------------
module tlvd_emit #(
    parameter int MAX_PAYLOAD = tlvd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [3:0]                     entry,
    input  logic [7:0]                     message_id,
    output logic                           rd_en,
    output logic [$clog2(MAX_PAYLOAD)-1:0] rd_addr,
    input  logic [7:0]                     rd_data,
    output logic                           fld_valid,
    output tlvd_pkg::out_item_t            fld_item,
    input  logic                           fld_ack
);

    localparam int AW = $clog2(MAX_PAYLOAD);

    tlvd_pkg::em_state_t state_reg, state_next;
    logic [3:0]  entry_reg, entry_next;
    logic [3:0]  field_reg, field_next;
    logic [1:0]  byte_reg, byte_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [31:0] acc_reg, acc_next;
    tlvd_pkg::kind_t kind;
    logic        is_last;

    assign kind    = tlvd_pkg::field_kind_of(entry_reg, field_reg);
    assign is_last = (field_reg == tlvd_pkg::last_field(entry_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlvd_pkg::EM_IDLE;
        end else begin
            state_reg <= state_next;
        end
        entry_reg <= entry_next;
        field_reg <= field_next;
        byte_reg  <= byte_next;
        pos_reg   <= pos_next;
        acc_reg   <= acc_next;
    end

    always_comb begin
        state_next = state_reg;
        entry_next = entry_reg;
        field_next = field_reg;
        byte_next  = byte_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        rd_en      = 1'b0;
        fld_valid  = 1'b0;
        case (state_reg)
            tlvd_pkg::EM_IDLE: begin
                if (start) begin
                    entry_next = entry;
                    field_next = 4'd0;
                    byte_next  = 2'd0;
                    pos_next   = '0;
                    acc_next   = 32'd0;
                    state_next = tlvd_pkg::EM_READ;
                end
            end
            tlvd_pkg::EM_READ: begin
                rd_en      = 1'b1;
                state_next = tlvd_pkg::EM_ACC;
            end
            tlvd_pkg::EM_ACC: begin
                acc_next = {acc_reg[23:0], rd_data};
                pos_next = pos_reg + {{(AW-1){1'b0}}, 1'b1};
                if (byte_reg == tlvd_pkg::kind_bytes_m1(kind)) begin
                    byte_next  = 2'd0;
                    state_next = tlvd_pkg::EM_PUSH;
                end else begin
                    byte_next  = byte_reg + 2'd1;
                    state_next = tlvd_pkg::EM_READ;
                end
            end
            tlvd_pkg::EM_PUSH: begin
                fld_valid = 1'b1;
                if (fld_ack) begin
                    acc_next = 32'd0;
                    if (is_last) begin
                        state_next = tlvd_pkg::EM_IDLE;
                    end else begin
                        field_next = field_reg + 4'd1;
                        state_next = tlvd_pkg::EM_READ;
                    end
                end
            end
            default: begin
                state_next = tlvd_pkg::EM_IDLE;
            end
        endcase
    end

    assign rd_addr = pos_reg;

    always_comb begin
        fld_item.status       = tlvd_pkg::STAT_FIELD;
        fld_item.message_id   = message_id;
        fld_item.table_entry  = entry_reg;
        fld_item.field_number = field_reg;
        fld_item.field_kind   = kind;
        fld_item.field_value  = acc_reg;
        fld_item.last         = is_last;
    end

endmodule
